[src/png_idat_stored_zlib_framer_unit_macros.svh]
// ----------------------------------------------------------------------------
// PNG IDAT framer assertion macros
// Immediate-implication and next-cycle-implication checks on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PNG_IDAT_STORED_ZLIB_FRAMER_UNIT_MACROS_SVH
`define PNG_IDAT_STORED_ZLIB_FRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PIDAT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidat: implication check failed");
`define PIDAT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidat: next-cycle check failed");
`else
`define PIDAT_ASSERT_IMP(name, ante, cons)
`define PIDAT_ASSERT_NXT(name, ante, cons)
`endif

`endif

[src/pidat_pkg.sv]
// ----------------------------------------------------------------------------
// pidat_pkg
// Shared types, constants and checksum helpers of the IDAT framer.
// ----------------------------------------------------------------------------
package pidat_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD      = 17'd65521;
    localparam logic [15:0] BLOCK_MAX      = 16'hFFFF;
    localparam logic [31:0] ZLEN_FIXED     = 32'd6;

    localparam logic [3:0]  HDR_TYPE_FIRST = 4'd4;
    localparam logic [3:0]  HDR_LAST       = 4'd9;
    localparam logic [3:0]  BLK_LAST       = 4'd4;
    localparam logic [3:0]  WORD_LAST      = 4'd3;

    localparam logic [7:0] HDR_TAIL [0:5] = '{8'h49, 8'h44, 8'h41, 8'h54, 8'h78, 8'h01};

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        blk;
        logic        fin;
        logic        last;
        logic [15:0] blen;
        logic [31:0] adler;
        logic [31:0] zlen;
    } entry_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
        logic [1:0] pos;
        pos = ~idx;
        return word[{pos, 3'b000} +: 8];
    endfunction

endpackage

[src/pidat_front.sv]
// ----------------------------------------------------------------------------
// pidat_front
// Accepts raw bytes, tracks chunk and block counts, updates Adler-32 and
// pushes one classified entry per byte into the work queue.
// ----------------------------------------------------------------------------
`include "png_idat_stored_zlib_framer_unit_macros.svh"

module pidat_front #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LENGTH_WIDTH-1:0] cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              data_byte,
    output logic                    q_wr,
    output pidat_pkg::entry_t       q_entry,
    input  logic                    q_full
);

    localparam int LW = LENGTH_WIDTH;
    localparam int BW = LW - 15;

    logic [LW-1:0] eff_reg;
    logic [BW-1:0] blocks_reg;
    logic [LW-1:0] rem_reg;
    logic [15:0]   brem_reg;
    logic [15:0]   lo_reg;
    logic [15:0]   hi_reg;

    logic [LW-1:0] cfg_sat;
    logic [16:0]   cfg_sum;
    logic [BW-1:0] cfg_blocks;

    logic          accept;
    logic          start;
    logic [LW-1:0] rem;
    logic [15:0]   brem;
    logic          blk;
    logic          big;
    logic [15:0]   blen;
    logic [15:0]   lo0;
    logic [15:0]   hi0;
    logic [16:0]   lo_sum;
    logic [16:0]   lo_red;
    logic [15:0]   lo1;
    logic [16:0]   hi_sum;
    logic [16:0]   hi_red;
    logic [15:0]   hi1;
    logic          last;
    logic [31:0]   zlen;

    assign cfg_ready  = 1'b1;
    assign cfg_sat    = (cfg_data[LW-1:1] == '0) ? LW'(2) : cfg_data;
    assign cfg_sum    = {1'b0, cfg_sat[15:0]} + 17'(cfg_sat[LW-1:16]);
    assign cfg_blocks = BW'(cfg_sat[LW-1:16]) + BW'(1) + BW'(cfg_sum[16]);

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_wr   = accept;

    assign start  = (rem_reg == '0);
    assign rem    = start ? eff_reg : rem_reg;
    assign brem   = start ? 16'd0 : brem_reg;
    assign blk    = (brem == 16'd0);
    assign big    = |rem[LW-1:16];
    assign blen   = big ? pidat_pkg::BLOCK_MAX : rem[15:0];
    assign last   = (rem == LW'(1));

    assign lo0    = start ? 16'd1 : lo_reg;
    assign hi0    = start ? 16'd0 : hi_reg;
    assign lo_sum = {1'b0, lo0} + {9'd0, data_byte};
    assign lo_red = lo_sum - pidat_pkg::ADLER_MOD;
    assign lo1    = (lo_sum >= pidat_pkg::ADLER_MOD) ? lo_red[15:0] : lo_sum[15:0];
    assign hi_sum = {1'b0, hi0} + {1'b0, lo1};
    assign hi_red = hi_sum - pidat_pkg::ADLER_MOD;
    assign hi1    = (hi_sum >= pidat_pkg::ADLER_MOD) ? hi_red[15:0] : hi_sum[15:0];

    assign zlen = 32'(eff_reg) + pidat_pkg::ZLEN_FIXED + 32'({blocks_reg, 2'b00})
                + 32'(blocks_reg);

    always_comb
    begin
        q_entry.data  = data_byte;
        q_entry.start = start;
        q_entry.blk   = blk;
        q_entry.fin   = !big;
        q_entry.last  = last;
        q_entry.blen  = blen;
        q_entry.adler = {hi1, lo1};
        q_entry.zlen  = zlen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg    <= LW'(2);
            blocks_reg <= BW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            eff_reg    <= cfg_sat;
            blocks_reg <= cfg_blocks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            brem_reg <= 16'd0;
            lo_reg   <= 16'd1;
            hi_reg   <= 16'd0;
        end
        else if (accept)
        begin
            rem_reg  <= rem - LW'(1);
            brem_reg <= (blk ? blen : brem) - 16'd1;
            lo_reg   <= lo1;
            hi_reg   <= hi1;
        end
    end

    `PIDAT_ASSERT_IMP(a_start_opens_block, accept && start, blk)
    `PIDAT_ASSERT_NXT(a_last_closes_chunk, accept && last, rem_reg == '0)

endmodule

[src/pidat_queue.sv]
// ----------------------------------------------------------------------------
// pidat_queue
// Short entry queue between the classifying front and the byte serializer.
// ----------------------------------------------------------------------------
`include "png_idat_stored_zlib_framer_unit_macros.svh"

module pidat_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  pidat_pkg::entry_t wr_entry,
    output logic              full,
    input  logic              rd_en,
    output pidat_pkg::entry_t rd_entry,
    output logic              empty
);

    localparam int AW = pidat_pkg::Q_AW;

    pidat_pkg::entry_t slots [pidat_pkg::Q_DEPTH];
    logic [AW:0]       wr_ptr_reg;
    logic [AW:0]       rd_ptr_reg;
    logic              do_wr;
    logic              do_rd;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                   && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = slots[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg[AW-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + (AW+1)'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + (AW+1)'(1);
            end
        end
    end

    `PIDAT_ASSERT_NXT(a_q_fill, do_wr && !do_rd, !empty)

endmodule

[src/pidat_back.sv]
// ----------------------------------------------------------------------------
// pidat_back
// Serializes queue entries into chunk bytes (chunk header, stored block header,
// data, Adler-32 and CRC-32), one byte per clock into the output stage unless stalled.
// ----------------------------------------------------------------------------
`include "png_idat_stored_zlib_framer_unit_macros.svh"

module pidat_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pidat_pkg::entry_t q_head,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              last_of_run,
    output logic              chunk_done
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_HDR   = 6'b000010,
        ST_BLK   = 6'b000100,
        ST_DATA  = 6'b001000,
        ST_ADLER = 6'b010000,
        ST_CRC   = 6'b100000
    } back_state_t;

    back_state_t       state_reg;
    logic [3:0]        cnt_reg;
    pidat_pkg::entry_t cur_reg;
    logic [31:0]       crc_reg;
    logic [7:0]        obyte_reg;
    logic              olast_reg;
    logic              odone_reg;
    logic              ovalid_reg;

    back_state_t       nxt_state;
    back_state_t       first_state;
    logic [7:0]        emit_byte;
    logic              crc_en;
    logic              sec_end;
    logic              ent_end;
    logic              done_flag;
    logic              busy;
    logic              adv;
    logic              emit_go;
    logic              load;

    assign busy    = (state_reg != ST_IDLE);
    assign adv     = !ovalid_reg || pop;
    assign emit_go = busy && adv;
    assign load    = !q_empty && (!busy || (emit_go && ent_end));
    assign q_rd    = load;

    assign empty       = !ovalid_reg;
    assign out_byte    = obyte_reg;
    assign last_of_run = olast_reg;
    assign chunk_done  = odone_reg;

    always_comb
    begin
        if (q_head.start)
        begin
            first_state = ST_HDR;
        end
        else if (q_head.blk)
        begin
            first_state = ST_BLK;
        end
        else
        begin
            first_state = ST_DATA;
        end
    end

    always_comb
    begin
        emit_byte = 8'd0;
        crc_en    = 1'b0;
        sec_end   = 1'b0;
        ent_end   = 1'b0;
        done_flag = 1'b0;
        nxt_state = ST_IDLE;
        unique case (state_reg)
            ST_HDR:
            begin
                if (cnt_reg < pidat_pkg::HDR_TYPE_FIRST)
                begin
                    emit_byte = pidat_pkg::be_byte(cur_reg.zlen, cnt_reg[1:0]);
                end
                else
                begin
                    emit_byte = pidat_pkg::HDR_TAIL[3'(cnt_reg - pidat_pkg::HDR_TYPE_FIRST)];
                    crc_en    = 1'b1;
                end
                sec_end   = (cnt_reg == pidat_pkg::HDR_LAST);
                nxt_state = cur_reg.blk ? ST_BLK : ST_DATA;
            end
            ST_BLK:
            begin
                crc_en = 1'b1;
                unique case (cnt_reg)
                    4'd0:    emit_byte = {7'd0, cur_reg.fin};
                    4'd1:    emit_byte = cur_reg.blen[7:0];
                    4'd2:    emit_byte = cur_reg.blen[15:8];
                    4'd3:    emit_byte = ~cur_reg.blen[7:0];
                    default: emit_byte = ~cur_reg.blen[15:8];
                endcase
                sec_end   = (cnt_reg == pidat_pkg::BLK_LAST);
                nxt_state = ST_DATA;
            end
            ST_DATA:
            begin
                emit_byte = cur_reg.data;
                crc_en    = 1'b1;
                sec_end   = 1'b1;
                ent_end   = !cur_reg.last;
                nxt_state = cur_reg.last ? ST_ADLER : ST_IDLE;
            end
            ST_ADLER:
            begin
                emit_byte = pidat_pkg::be_byte(cur_reg.adler, cnt_reg[1:0]);
                crc_en    = 1'b1;
                sec_end   = (cnt_reg == pidat_pkg::WORD_LAST);
                nxt_state = ST_CRC;
            end
            ST_CRC:
            begin
                emit_byte = pidat_pkg::be_byte(crc_reg ^ pidat_pkg::CRC_INIT, cnt_reg[1:0]);
                sec_end   = (cnt_reg == pidat_pkg::WORD_LAST);
                ent_end   = sec_end;
                done_flag = sec_end;
                nxt_state = ST_IDLE;
            end
            default:
            begin
                nxt_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_head;
        end
        if (emit_go)
        begin
            obyte_reg <= emit_byte;
            olast_reg <= ent_end;
            odone_reg <= done_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 4'd0;
            crc_reg    <= pidat_pkg::CRC_INIT;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (emit_go)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end

            if (load && q_head.start)
            begin
                crc_reg <= pidat_pkg::CRC_INIT;
            end
            else if (emit_go && crc_en)
            begin
                crc_reg <= pidat_pkg::crc_byte(crc_reg, emit_byte);
            end

            if (load)
            begin
                state_reg <= first_state;
                cnt_reg   <= 4'd0;
            end
            else if (emit_go)
            begin
                if (sec_end)
                begin
                    state_reg <= nxt_state;
                    cnt_reg   <= 4'd0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
        end
    end

    `PIDAT_ASSERT_IMP(a_done_is_last, ovalid_reg && odone_reg, olast_reg)
    `PIDAT_ASSERT_NXT(a_crc_seed, load && q_head.start, crc_reg == pidat_pkg::CRC_INIT)
    `PIDAT_ASSERT_IMP(a_load_when_free, load, !busy || ent_end)

endmodule

[src/png_idat_stored_zlib_framer_unit.sv]
// ----------------------------------------------------------------------------
// png_idat_stored_zlib_framer_unit
// Wraps raw filtered image bytes into one PNG IDAT chunk with a stored
// zlib stream, Adler-32 and CRC-32.
// ----------------------------------------------------------------------------
// The block emits one chunk byte per clock while pop keeps the output stage
// free. Raw bytes in the middle of a stored block stream through at one per
// clock; the first byte of a chunk also brings the length, type, zlib header
// and first block header, the first byte of each later 65535-byte block
// brings its block header, and the last byte brings Adler-32 and CRC-32. The
// output serializer holds the running CRC and works one byte per cycle when
// not stalled; a two-entry queue lets input keep arriving while it is busy.
// The cfg_data length is sampled at chunk start; values below 2 are treated as 2.
module png_idat_stored_zlib_framer_unit #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LENGTH_WIDTH-1:0] cfg_data,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              data_byte,
    output logic                    empty,
    input  logic                    pop,
    output logic [7:0]              out_byte,
    output logic                    last_of_run,
    output logic                    chunk_done
);

    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    pidat_pkg::entry_t q_wr_entry;
    pidat_pkg::entry_t q_head;

    pidat_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .q_wr      (q_wr),
        .q_entry   (q_wr_entry),
        .q_full    (q_full)
    );

    pidat_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .rd_en    (q_rd),
        .rd_entry (q_head),
        .empty    (q_empty)
    );

    pidat_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .chunk_done  (chunk_done)
    );

endmodule
